>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the keypad scanner and code lock modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

>>> hdl/kscl_pkg.sv
// ----------------------------------------------------------------------------
// kscl_pkg
// Types, constants and lookup tables of the keypad scanner and code lock.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kscl_pkg;

	// Code lock geometry.
	localparam int CODE_LENGTH = 6;
	localparam int NUM_CODES   = 6;
	localparam int KEY_W       = 4;
	localparam int CODE_W      = 24;
	localparam int ENTRY_W     = KEY_W * CODE_LENGTH;
	localparam int CMP_W       = (ENTRY_W > CODE_W) ? ENTRY_W : CODE_W;
	localparam int CNT_W       = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
	localparam int CFG_IDX_W   = 3;

	// Scanner geometry.
	localparam int IDX_W   = 2;
	localparam int ROW_W   = 2;
	localparam int DRIVE_W = 4;
	localparam int CHAR_W  = 7;

	// No column driven.
	localparam logic [DRIVE_W-1:0] DRIVE_IDLE = 4'hF;

	// Request kinds carried in the input tuser bit.
	localparam logic REQ_TICK = 1'b0;
	localparam logic REQ_KEY  = 1'b1;

	typedef enum logic [1:0] {
		VERDICT_NONE = 2'd0,
		VERDICT_OK   = 2'd1,
		VERDICT_BAD  = 2'd2
	} verdict_t;

	// Reset values of the code registers.
	localparam logic [CODE_W-1:0] CODE_RESET [NUM_CODES] = '{
		24'h01237B, 24'h104101, 24'h37B012, 24'h37B37B, 24'h012456, 24'h000000
	};

	// Key press handed from the scanner side to the lock.
	typedef struct packed {
		logic             press;
		logic [KEY_W-1:0] key;
	} key_cmd_t;

	// Scanner state as seen by the datapath.
	typedef struct packed {
		logic [IDX_W-1:0]   idx;
		logic [DRIVE_W-1:0] drive_next;
	} scan_t;

	// Active-low column pattern for a scan index.
	function automatic logic [DRIVE_W-1:0] col_pattern(input logic [IDX_W-1:0] idx);
		logic [DRIVE_W-1:0] p;
		unique case (idx)
			2'd0:    p = 4'hD;
			2'd1:    p = 4'hB;
			2'd2:    p = 4'h7;
			default: p = 4'hE;
		endcase
		return p;
	endfunction

	// ASCII character of a key in the 4x4 layout.
	function automatic logic [CHAR_W-1:0] key_char(input logic [KEY_W-1:0] key);
		logic [CHAR_W-1:0] c;
		unique case (key)
			4'd0:    c = 7'h31;
			4'd1:    c = 7'h32;
			4'd2:    c = 7'h33;
			4'd3:    c = 7'h41;
			4'd4:    c = 7'h34;
			4'd5:    c = 7'h35;
			4'd6:    c = 7'h36;
			4'd7:    c = 7'h42;
			4'd8:    c = 7'h37;
			4'd9:    c = 7'h38;
			4'd10:   c = 7'h39;
			4'd11:   c = 7'h43;
			4'd12:   c = 7'h2A;
			4'd13:   c = 7'h30;
			4'd14:   c = 7'h23;
			default: c = 7'h44;
		endcase
		return c;
	endfunction

endpackage

>>> hdl/kscl_scan.sv
// ----------------------------------------------------------------------------
// kscl_scan
// Column scan sequencer: scan index and held column drive pattern.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module kscl_scan (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          tick,
	output kscl_pkg::scan_t scan
);

	logic [kscl_pkg::IDX_W-1:0]   idx_q;
	logic [kscl_pkg::DRIVE_W-1:0] drive_q;

	// A tick drives the pattern of the current index, then moves to the next column.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			drive_q <= kscl_pkg::DRIVE_IDLE;
		end else if (tick) begin
			idx_q   <= idx_q + kscl_pkg::IDX_W'(1);
			drive_q <= kscl_pkg::col_pattern(idx_q);
		end
	end

	// Drive value after the step being committed now.
	always_comb begin
		scan.idx        = idx_q;
		scan.drive_next = tick ? kscl_pkg::col_pattern(idx_q) : drive_q;
	end

	`ASSERT_NXT(a_tick_drive, clk, arst_n, tick, drive_q == kscl_pkg::col_pattern($past(idx_q)))
	`ASSERT_NXT(a_idle_hold, clk, arst_n, !tick, $stable(idx_q) && $stable(drive_q))

endmodule

>>> hdl/kscl_lock.sv
// ----------------------------------------------------------------------------
// kscl_lock
// Code lock: code registers, entry buffer, and the compare on the last key.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module kscl_lock (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [kscl_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [kscl_pkg::CODE_W-1:0]      cfg_wdata,
	input  kscl_pkg::key_cmd_t               cmd,
	output kscl_pkg::verdict_t               verdict
);

	logic [kscl_pkg::CODE_W-1:0]  code_q  [kscl_pkg::NUM_CODES];
	logic [kscl_pkg::KEY_W-1:0]   entry_q [kscl_pkg::CODE_LENGTH];
	logic [kscl_pkg::CNT_W-1:0]   cnt_q;
	logic                         last_key;
	logic [kscl_pkg::ENTRY_W-1:0] packed_entry;
	logic                         hit;

	// Code registers; writes beyond the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < kscl_pkg::NUM_CODES; i++) begin
				code_q[i] <= kscl_pkg::CODE_RESET[i];
			end
		end else if (cfg_we) begin
			for (int i = 0; i < kscl_pkg::NUM_CODES; i++) begin
				if (cfg_index == kscl_pkg::CFG_IDX_W'(i)) begin
					code_q[i] <= cfg_wdata;
				end
			end
		end
	end

	assign last_key = (cnt_q == kscl_pkg::CNT_W'(kscl_pkg::CODE_LENGTH - 1));

	// Entry count restarts after the last key of a code.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.press) begin
			cnt_q <= last_key ? '0 : cnt_q + kscl_pkg::CNT_W'(1);
		end
	end

	// Entry buffer holds keys only; it is always written before it is read.
	always_ff @(posedge clk) begin
		if (cmd.press) begin
			for (int i = 0; i < kscl_pkg::CODE_LENGTH; i++) begin
				if (cnt_q == kscl_pkg::CNT_W'(i)) begin
					entry_q[i] <= cmd.key;
				end
			end
		end
	end

	// Pack the entry with the first key on top; the final key comes straight in.
	always_comb begin
		packed_entry = '0;
		for (int i = 0; i < kscl_pkg::CODE_LENGTH; i++) begin
			packed_entry[kscl_pkg::ENTRY_W-1-kscl_pkg::KEY_W*i -: kscl_pkg::KEY_W] =
				(i == kscl_pkg::CODE_LENGTH - 1) ? cmd.key : entry_q[i];
		end
	end

	// Compare against every code in parallel.
	always_comb begin
		hit = 1'b0;
		for (int i = 0; i < kscl_pkg::NUM_CODES; i++) begin
			if (kscl_pkg::CMP_W'(packed_entry) == kscl_pkg::CMP_W'(code_q[i])) begin
				hit = 1'b1;
			end
		end
	end

	always_comb begin
		if (cmd.press && last_key) begin
			verdict = hit ? kscl_pkg::VERDICT_OK : kscl_pkg::VERDICT_BAD;
		end else begin
			verdict = kscl_pkg::VERDICT_NONE;
		end
	end

	`ASSERT_NXT(a_cnt_wrap, clk, arst_n, cmd.press && last_key, cnt_q == '0)

endmodule

>>> hdl/keypad_scan_code_lock.sv
// ----------------------------------------------------------------------------
// keypad_scan_code_lock
// 4x4 matrix keypad scanner with a six-key code lock.
// ----------------------------------------------------------------------------
// The input stream carries one request per item: s_tuser is the request kind
// (0 scan tick, 1 key row event) and s_tdata[1:0] is the row of a key event.
// Every request gives exactly one result on the output stream: the column
// drive now applied, and for a key event the key index, its character and,
// on the last key of a code, the verdict. m_tuser flags a decoded key.
// A request passes an input register and a result register: it moves into
// the result register once that is empty or its result is being taken.
// One request is taken every cycle while the receiver keeps up; the scanner
// and lock state are updated in the single cycle in which a request moves
// into the result register. When the receiver stalls, the result holds and
// the input register fills, after which s_tready drops until the result is
// taken. Reset clears both stream registers, sets the scan index to zero,
// drives no column, clears the key count and loads the default codes. Code
// registers are written through cfg_we, cfg_index and cfg_wdata; the user
// must write them only while idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module keypad_scan_code_lock (
	input  logic        clk,
	input  logic        arst_n,
	// Request stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,    // [1:0] row, [7:2] zero
	input  logic        s_tuser,    // [0] req_type
	// Result stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,    // [3:0] column_drive, [7:4] key_index,
	                                // [14:8] key_char, [16:15] verdict, [23:17] zero
	output logic        m_tuser,    // [0] key_valid
	// Configuration write port.
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_wdata
);

	logic                          valid_s1;
	logic                          req_s1;
	logic [kscl_pkg::ROW_W-1:0]    row_s1;
	logic                          valid_s2;
	logic [kscl_pkg::DRIVE_W-1:0]  drive_s2;
	logic                          key_valid_s2;
	logic [kscl_pkg::KEY_W-1:0]    key_s2;
	logic [kscl_pkg::CHAR_W-1:0]   char_s2;
	kscl_pkg::verdict_t            verdict_s2;

	logic                          adv_s2;
	logic                          move_s1;
	logic                          s_acc;
	logic [kscl_pkg::KEY_W-1:0]    key;
	kscl_pkg::key_cmd_t            cmd;
	kscl_pkg::scan_t               scan;
	kscl_pkg::verdict_t            verdict;

	// Pipeline flow control.
	assign adv_s2   = !valid_s2 || m_tready;
	assign move_s1  = valid_s1 && adv_s2;
	assign s_tready = !valid_s1 || adv_s2;
	assign s_acc    = s_tvalid && s_tready;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			req_s1 <= s_tuser;
			row_s1 <= s_tdata[kscl_pkg::ROW_W-1:0];
		end
	end

	// Key decode from the row and the current scan column.
	assign key = {row_s1, scan.idx};

	always_comb begin
		cmd.press = move_s1 && (req_s1 == kscl_pkg::REQ_KEY);
		cmd.key   = key;
	end

	kscl_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (move_s1 && (req_s1 == kscl_pkg::REQ_TICK)),
		.scan   (scan)
	);

	kscl_lock u_lock (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.verdict   (verdict)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			drive_s2 <= scan.drive_next;
			if (req_s1 == kscl_pkg::REQ_KEY) begin
				key_valid_s2 <= 1'b1;
				key_s2       <= key;
				char_s2      <= kscl_pkg::key_char(key);
				verdict_s2   <= verdict;
			end else begin
				key_valid_s2 <= 1'b0;
				key_s2       <= '0;
				char_s2      <= '0;
				verdict_s2   <= kscl_pkg::VERDICT_NONE;
			end
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = key_valid_s2;
	assign m_tdata  = {7'd0, verdict_s2, char_s2, key_s2, drive_s2};

	`ASSERT_IMP(a_tick_fields, clk, arst_n, valid_s2 && !key_valid_s2,
		key_s2 == '0 && char_s2 == '0 && verdict_s2 == kscl_pkg::VERDICT_NONE)
	`ASSERT_IMP(a_stall_only, clk, arst_n, !s_tready, valid_s1 && valid_s2 && !m_tready)
	`ASSERT_NXT(a_s1_hold, clk, arst_n, valid_s1 && !adv_s2, valid_s1 && $stable(req_s1))

endmodule

>>> bench/lock_result_checker.sv
// ----------------------------------------------------------------------------
// lock_result_checker
// Watches the request, result and register write channels of the keypad
// scanner and code lock, predicts each result from its own copy of the scan
// and lock state, and compares every result field with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lock_result_checker
	import kscl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic        s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,
	input  logic        m_tuser,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_wdata,
	output int unsigned pending,
	output int unsigned fail_count
);

	// One predicted result, field by field.
	typedef struct packed {
		logic [DRIVE_W-1:0] drive;
		logic               key_valid;
		logic [KEY_W-1:0]   key_index;
		logic [CHAR_W-1:0]  key_char;
		verdict_t           verdict;
	} lock_result_t;

	// Column patterns by scan position, and the keypad face row by row.
	localparam logic [DRIVE_W-1:0] COL_DRIVE [4] = '{4'hD, 4'hB, 4'h7, 4'hE};
	localparam logic [8*16-1:0]    LAYOUT        = "123A456B789C*0#D";

	logic [CODE_W-1:0]  lock_codes [NUM_CODES];
	logic [IDX_W-1:0]   col_now;
	logic [DRIVE_W-1:0] drive_now;
	int                 keys_held;
	logic [KEY_W-1:0]   entry [CODE_LENGTH];
	lock_result_t       due_results [$];

	// Applies one request to the scan and lock state and returns its result.
	function automatic lock_result_t advance_lock(input logic kind,
	                                              input logic [ROW_W-1:0] row);
		lock_result_t           r;
		logic [CMP_W-1:0]       entry_word;
		logic                   hit;
		int                     i;
		r = '0;
		if (kind == REQ_TICK) begin
			drive_now = COL_DRIVE[col_now];
			col_now   = col_now + 1'b1;
		end else begin
			r.key_valid = 1'b1;
			r.key_index = {row, col_now};
			r.key_char  = LAYOUT[8 * (15 - int'(r.key_index)) +: CHAR_W];
			entry[keys_held] = r.key_index;
			keys_held++;
			// The last key of an entry triggers the compare against every code.
			if (keys_held == CODE_LENGTH) begin
				keys_held  = 0;
				entry_word = '0;
				for (i = 0; i < CODE_LENGTH; i++)
					entry_word = (entry_word << KEY_W) | CMP_W'(entry[i]);
				hit = 1'b0;
				for (i = 0; i < NUM_CODES; i++)
					if (entry_word == CMP_W'(lock_codes[i]))
						hit = 1'b1;
				r.verdict = hit ? VERDICT_OK : VERDICT_BAD;
			end
		end
		r.drive = drive_now;
		return r;
	endfunction

	task automatic flag(input string what, input int unsigned want,
	                    input int unsigned got);
		fail_count++;
		$display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
	endtask

	// Register writes, result compare and request prediction, in that order.
	always @(posedge clk or negedge arst_n) begin
		lock_result_t want;
		if (!arst_n) begin
			for (int i = 0; i < NUM_CODES; i++)
				lock_codes[i] = CODE_RESET[i];
			col_now    = '0;
			drive_now  = DRIVE_IDLE;
			keys_held  = 0;
			due_results.delete();
			fail_count = 0;
			pending   <= 0;
		end else begin
			if (cfg_we && cfg_index < NUM_CODES)
				lock_codes[cfg_index] = cfg_wdata;
			if (m_tvalid && m_tready) begin
				if (due_results.size() == 0) begin
					flag("result with no request pending", 0, m_tdata);
				end else begin
					want = due_results.pop_front();
					if (m_tdata[3:0] !== want.drive)
						flag("column_drive", want.drive, m_tdata[3:0]);
					if (m_tuser !== want.key_valid)
						flag("key_valid", want.key_valid, m_tuser);
					if (m_tdata[7:4] !== want.key_index)
						flag("key_index", want.key_index, m_tdata[7:4]);
					if (m_tdata[14:8] !== want.key_char)
						flag("key_char", want.key_char, m_tdata[14:8]);
					if (m_tdata[16:15] !== want.verdict)
						flag("verdict", want.verdict, m_tdata[16:15]);
					if (m_tdata[23:17] !== '0)
						flag("padding", 0, m_tdata[23:17]);
				end
			end
			if (s_tvalid && s_tready)
				due_results.push_back(advance_lock(s_tuser, s_tdata[ROW_W-1:0]));
			pending <= due_results.size();
		end
	end

endmodule

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives key row events, scan ticks and code register writes into the keypad
// scanner and code lock, with random idling on both streams, a long result
// stall and drained pauses, and reports the checker's verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
	import kscl_pkg::*;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = '0;
	logic        s_tuser   = REQ_TICK;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [23:0] m_tdata;
	logic        m_tuser;
	logic        cfg_we    = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [23:0] cfg_wdata = '0;

	int unsigned pending;
	int unsigned fail_count;

	// Stimulus bookkeeping: steady mode, hold-off asks, scan position, keys into the current entry, requests sent, codes.
	logic              steady     = 1'b0;
	int unsigned       hold_asks  = 0;
	int unsigned       hold_taken = 0;
	int unsigned       hold_left  = 0;
	logic [IDX_W-1:0]  scan_pos   = '0;
	int                key_phase  = 0;
	int unsigned       sent       = 0;
	logic [CODE_W-1:0] lock_codes [NUM_CODES];

	keypad_scan_code_lock u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	lock_result_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.pending    (pending),
		.fail_count (fail_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Result side: random stalls, or a long hold-off when one is asked for.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			m_tready  <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_taken != hold_asks) begin
			hold_taken <= hold_asks;
			hold_left  <= 300;
			m_tready   <= 1'b0;
		end else begin
			m_tready <= steady || ($urandom_range(99) >= 37);
		end
	end

	// Offers one request, waits for it to be taken, then maybe idles a while.
	task automatic offer_request(input logic kind, input logic [ROW_W-1:0] row);
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {6'd0, row};
		do @(posedge clk); while (!s_tready);
		sent++;
		if (kind == REQ_TICK)
			scan_pos++;
		else
			key_phase = (key_phase + 1) % CODE_LENGTH;
		if (!steady && $urandom_range(99) < 37) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 37);
		end
	endtask

	// Ticks the scan round to the key's column, then reports its row.
	task automatic press_key(input logic [KEY_W-1:0] key);
		while (scan_pos != key[IDX_W-1:0])
			offer_request(REQ_TICK, ROW_W'($urandom_range(3)));
		offer_request(REQ_KEY, key[KEY_W-1:IDX_W]);
	endtask

	// Keys in a whole code, first key from the top nibble, with stray ticks.
	task automatic enter_code(input logic [CODE_W-1:0] code);
		int i;
		for (i = 0; i < CODE_LENGTH; i++) begin
			if ($urandom_range(4) == 0)
				repeat ($urandom_range(1, 4))
					offer_request(REQ_TICK, ROW_W'($urandom_range(3)));
			press_key(code[KEY_W * (CODE_LENGTH - 1 - i) +: KEY_W]);
		end
	endtask

	// Stops offering and waits until every predicted result has been taken.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// Drives one register write; the caller lowers the enable after a batch.
	task automatic write_code_reg(input logic [2:0] idx, input logic [CODE_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		if (idx < NUM_CODES)
			lock_codes[idx] = val;
	endtask

	// Mostly realigned code entries (right, near miss, random), some noise.
	task automatic run_random(input int unsigned until_sent);
		int                roll;
		int                nib;
		logic [CODE_W-1:0] code;
		while (sent < until_sent) begin
			roll = $urandom_range(99);
			if (roll < 75) begin
				// An occasional entry starts mid-buffer, and so comes out broken.
				if ($urandom_range(9) != 0)
					while (key_phase != 0)
						press_key(KEY_W'($urandom_range(15)));
				roll = $urandom_range(99);
				if (roll < 55) begin
					code = lock_codes[$urandom_range(NUM_CODES - 1)];
				end else if (roll < 80) begin
					code = lock_codes[$urandom_range(NUM_CODES - 1)];
					nib  = $urandom_range(CODE_LENGTH - 1);
					code[KEY_W * nib +: KEY_W] = code[KEY_W * nib +: KEY_W] ^
						KEY_W'($urandom_range(1, 15));
				end else begin
					code = CODE_W'($urandom());
				end
				enter_code(code);
			end else begin
				repeat ($urandom_range(1, 6))
					offer_request(1'($urandom_range(1)), ROW_W'($urandom_range(3)));
			end
		end
	endtask

	initial begin
		int i;
		for (i = 0; i < NUM_CODES; i++)
			lock_codes[i] = CODE_RESET[i];
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A key before any tick sees no column driven; then one full scan turn.
		offer_request(REQ_KEY, 2'd0);
		repeat (4) offer_request(REQ_TICK, 2'd3);
		// Bottom-row keys complete a wrong entry; six zero keys match code_5.
		repeat (5) offer_request(REQ_KEY, 2'd3);
		repeat (6) offer_request(REQ_KEY, 2'd0);
		// Last column, last row.
		repeat (3) offer_request(REQ_TICK, 2'd1);
		offer_request(REQ_KEY, 2'd3);
		repeat (5) press_key(KEY_W'($urandom_range(15)));
		enter_code(lock_codes[0]);
		drain_results();

		// Default codes, opening with a long result stall under a full sender.
		hold_asks <= hold_asks + 1;
		steady    <= 1'b1;
		repeat (40) offer_request(1'($urandom_range(1)), ROW_W'($urandom_range(3)));
		steady <= 1'b0;
		run_random(350);
		drain_results();
		run_random(400);
		drain_results();

		// Extreme codes, and writes past the register list that must do nothing.
		for (i = 0; i < NUM_CODES - 1; i++)
			write_code_reg(3'(i), 24'hFFFFFF);
		write_code_reg(3'(NUM_CODES - 1), 24'h000000);
		write_code_reg(3'd6, CODE_W'($urandom()));
		write_code_reg(3'd7, CODE_W'($urandom()));
		cfg_we <= 1'b0;
		steady <= 1'b1;
		run_random(650);
		steady <= 1'b0;
		run_random(750);
		drain_results();

		// Random codes.
		for (i = 0; i < NUM_CODES; i++)
			write_code_reg(3'(i), CODE_W'($urandom()));
		cfg_we <= 1'b0;
		run_random(1150);
		drain_results();

		// Back to the default codes.
		for (i = 0; i < NUM_CODES; i++)
			write_code_reg(3'(i), CODE_RESET[i]);
		cfg_we <= 1'b0;
		run_random(1520);
		drain_results();

		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// Run limit.
	initial begin
		#5_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+hdl
hdl/kscl_pkg.sv
hdl/kscl_scan.sv
hdl/kscl_lock.sv
hdl/keypad_scan_code_lock.sv
bench/lock_result_checker.sv
bench/testbench.sv
